### hw/rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed: lbl");
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition: lbl");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

### hw/rtl/upa_pkg.sv
// Package of the unique position allocator: request codes, register
// indexes, field widths and the control struct that drives the slot cells.
// No dependencies.
`default_nettype none

package upa_pkg;

  // Fixed field widths.
  localparam int REQ_W   = 3;
  localparam int SLOT_W  = 4;
  localparam int POS_W   = 4;
  localparam int RES_W   = 5;
  localparam int CFG_W   = 5;
  localparam int CFG_IDX_W = 1;
  // Wide enough for any count up to the largest parameter value (64).
  localparam int CNT_W   = 7;

  // Default sizes.
  localparam int DEF_MAX_SLOTS     = 16;
  localparam int DEF_MAX_POSITIONS = 16;

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_GET     = 3'd0,
    REQ_SET     = 3'd1,
    REQ_NEXT    = 3'd2,
    REQ_PREV    = 3'd3,
    REQ_DISABLE = 3'd4
  } req_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_COUNT  = 1'b1;

  // Result position reported for a disabled or out-of-range slot.
  localparam logic [RES_W-1:0] RES_DISABLED = 5'h1F;

  // Controls broadcast along the row of slot cells.
  typedef struct packed {
    logic [SLOT_W-1:0] self_slot;   // slot left out of the occupancy mask
    logic              load;        // write the slot named by load_slot
    logic [SLOT_W-1:0] load_slot;
    logic              load_valid;  // new enable state of that slot
    logic              clr;         // disable every cell at or above clr_from
    logic [CNT_W-1:0]  clr_from;
  } upa_cell_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/upa_cell.sv
// One slot cell of the unique position allocator: holds a slot's enable
// bit and position and adds its position to the occupancy mask it passes on.
// Depends on upa_pkg.
`default_nettype none

module upa_cell #(
  parameter int MAX_POSITIONS = 16,
  parameter int PW            = 4,
  parameter int IDX           = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  upa_pkg::upa_cell_ctrl_t ctrl,
  input  logic [PW-1:0]          load_pos,
  input  logic [MAX_POSITIONS-1:0] mask_in,
  output logic [MAX_POSITIONS-1:0] mask_out,
  output logic                   valid_o,
  output logic [PW-1:0]          pos_o
);
  import upa_pkg::*;

  logic          valid;
  logic [PW-1:0] pos;
  logic [MAX_POSITIONS-1:0] own;
  logic          is_self;
  logic          is_load;
  logic          is_clr;

  assign is_self = (IDX == int'(ctrl.self_slot));
  assign is_load = ctrl.load && (IDX == int'(ctrl.load_slot));
  assign is_clr  = ctrl.clr && (IDX >= int'(ctrl.clr_from));

  // Enable bit: cleared by reset and by configuration, set or cleared by a request.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (is_clr) begin
      valid <= 1'b0;
    end else if (is_load) begin
      valid <= ctrl.load_valid;
    end
  end

  // Position payload, meaningful only while the slot is enabled.
  always_ff @(posedge clk) begin
    if (is_load) begin
      pos <= load_pos;
    end
  end

  // One-hot occupancy of this cell's position.
  always_comb begin
    for (int j = 0; j < MAX_POSITIONS; j++) begin
      own[j] = valid && (pos == PW'(j));
    end
  end

  // The requesting slot does not block its own position.
  assign mask_out = is_self ? mask_in : (mask_in | own);
  assign valid_o  = valid;
  assign pos_o    = pos;

endmodule

`default_nettype wire

### hw/rtl/unique_position_allocator.sv
// Top level of the unique position allocator: configuration registers,
// request sequencing, cyclic free-position search and the result register.
// Depends on upa_pkg, upa_cell and assert_macros.svh.
// Usage:
//   Requests arrive on the s_axis channel (tuser carries the request kind,
//   tdata the slot and the wanted position). Each request produces exactly
//   one result transaction on m_axis: the slot's position after the request
//   (-1 when disabled or out of range) and the ok flag. Configuration writes
//   use cfg_valid/cfg_index/cfg_data (index 0 slot_count, index 1
//   position_count); cfg_ready is always high. Writes are to be made only
//   while no request is outstanding; the block itself does not enforce it.
// Request sequence:
//   In the accept cycle the row of slot cells forms the occupancy mask of all
//   other slots; once the result register is free, the search runs and the chosen
//   slot cell is updated. The result is valid in the cycle after that. A new
//   request is taken only once the last one is loaded into the result register.
// Reset and stall:
//   Reset (rst, synchronous) disables all slots and sets slot_count to 0 and
//   position_count to 16. While m_axis_tready is low the result holds; one
//   more request may be accepted, and its search waits for the register.
`default_nettype none

`include "assert_macros.svh"

module unique_position_allocator #(
  parameter int MAX_SLOTS     = upa_pkg::DEF_MAX_SLOTS,
  parameter int MAX_POSITIONS = upa_pkg::DEF_MAX_POSITIONS
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [upa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [upa_pkg::CFG_W-1:0]      cfg_data,
  // Request channel.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [3:0] slot, [7:4] position
  input  logic [2:0]                     s_axis_tuser,  // [2:0] req_type
  // Result channel.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // [4:0] result_position, [7:5] zero
  output logic [0:0]                     m_axis_tuser   // [0] ok
);
  import upa_pkg::*;

  localparam int PW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;

  // Configuration registers.
  logic [CFG_W-1:0] slot_count;
  logic [CFG_W-1:0] position_count;

  // Request state.
  logic                     busy;
  logic [REQ_W-1:0]         req_q;
  logic [SLOT_W-1:0]        slot_q;
  logic [POS_W-1:0]         pos_q;
  logic [MAX_POSITIONS-1:0] mask_q;
  logic                     cur_valid_q;
  logic [PW-1:0]            cur_pos_q;
  logic                     in_range_q;

  // Result register.
  logic             out_valid;
  logic [RES_W-1:0] out_pos;
  logic             out_ok;

  // Derived values.
  logic [CNT_W-1:0] npos;
  logic [CNT_W-1:0] active;
  logic [CNT_W-1:0] new_active;
  logic             cfg_write;
  logic             in_accept;
  logic             fire;

  logic [SLOT_W-1:0] slot_in;
  logic [POS_W-1:0]  pos_in;

  upa_cell_ctrl_t   cell_ctrl;
  logic [PW-1:0]    load_pos;
  logic [MAX_POSITIONS-1:0] chain [MAX_SLOTS+1];
  logic             cell_valid [MAX_SLOTS];
  logic [PW-1:0]    cell_pos   [MAX_SLOTS];
  logic             cur_valid;
  logic [PW-1:0]    cur_pos;

  // Search signals.
  logic [MAX_POSITIONS-1:0] free;
  logic [MAX_POSITIONS-1:0] above;
  logic [MAX_POSITIONS-1:0] below;
  logic [MAX_POSITIONS-1:0] p_onehot;
  logic [MAX_POSITIONS-1:0] cur_onehot;
  logic [CNT_W-1:0] base;
  logic [CNT_W-1:0] fwd_above;
  logic [CNT_W-1:0] fwd_any;
  logic [CNT_W-1:0] bwd_below;
  logic [CNT_W-1:0] bwd_any;
  logic             new_valid;
  logic [PW-1:0]    new_pos;
  logic             new_ok;
  logic             do_load;
  logic [31:0]      new_pos_wide;

  assign slot_in = s_axis_tdata[3:0];
  assign pos_in  = s_axis_tdata[7:4];

  assign cfg_ready     = 1'b1;
  assign cfg_write     = cfg_valid && cfg_ready;
  assign s_axis_tready = !busy;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign fire          = busy && (!out_valid || m_axis_tready);

  // Effective position count and active slot count.
  always_comb begin
    logic [CNT_W-1:0] sc;
    logic [CNT_W-1:0] nv;
    npos = (CNT_W'(position_count) > CNT_W'(MAX_POSITIONS)) ?
           CNT_W'(MAX_POSITIONS) : CNT_W'(position_count);
    sc = CNT_W'(slot_count);
    active = (sc > npos) ? npos : sc;
    if (active > CNT_W'(MAX_SLOTS)) begin
      active = CNT_W'(MAX_SLOTS);
    end
    nv = CNT_W'(cfg_data);
    new_active = (nv > npos) ? npos : nv;
    if (new_active > CNT_W'(MAX_SLOTS)) begin
      new_active = CNT_W'(MAX_SLOTS);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count     <= '0;
      position_count <= 5'd16;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SLOT_COUNT: slot_count     <= cfg_data;
        CFG_POS_COUNT:  position_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Cell controls: mask exclusion, slot update and configuration clears.
  always_comb begin
    cell_ctrl.self_slot  = slot_in;
    cell_ctrl.load       = do_load;
    cell_ctrl.load_slot  = slot_q;
    cell_ctrl.load_valid = new_valid;
    cell_ctrl.clr        = cfg_write;
    cell_ctrl.clr_from   = (cfg_index == CFG_SLOT_COUNT) ? new_active : '0;
  end
  assign load_pos = new_pos;

  // Row of slot cells; the occupancy mask passes from cell to cell.
  assign chain[0] = '0;
  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    upa_cell #(
      .MAX_POSITIONS (MAX_POSITIONS),
      .PW            (PW),
      .IDX           (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (cell_ctrl),
      .load_pos (load_pos),
      .mask_in  (chain[i]),
      .mask_out (chain[i+1]),
      .valid_o  (cell_valid[i]),
      .pos_o    (cell_pos[i])
    );
  end

  // State of the requested slot.
  always_comb begin
    cur_valid = 1'b0;
    cur_pos   = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (i == int'(slot_in)) begin
        cur_valid = cell_valid[i];
        cur_pos   = cell_pos[i];
      end
    end
  end

  // Capture the request and its occupancy mask at acceptance.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_q       <= s_axis_tuser;
      slot_q      <= slot_in;
      pos_q       <= pos_in;
      mask_q      <= chain[MAX_SLOTS];
      cur_valid_q <= cur_valid;
      cur_pos_q   <= cur_pos;
      in_range_q  <= (CNT_W'(slot_in) < active);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_accept) begin
      busy <= 1'b1;
    end else if (fire) begin
      busy <= 1'b0;
    end
  end

  // Free positions and the split around the current position.
  always_comb begin
    base = cur_valid_q ? CNT_W'(cur_pos_q) : (npos - CNT_W'(1));
    for (int j = 0; j < MAX_POSITIONS; j++) begin
      free[j]       = !mask_q[j] && (CNT_W'(j) < npos);
      above[j]      = free[j] && (CNT_W'(j) > base);
      below[j]      = free[j] && (CNT_W'(j) < base);
      p_onehot[j]   = (j == int'(pos_q));
      cur_onehot[j] = (cur_pos_q == PW'(j));
    end
  end

  // Lowest free position above and overall; highest below and overall.
  always_comb begin
    fwd_above = '0;
    fwd_any   = '0;
    for (int j = MAX_POSITIONS - 1; j >= 0; j--) begin
      if (above[j]) fwd_above = CNT_W'(j);
      if (free[j])  fwd_any   = CNT_W'(j);
    end
    bwd_below = '0;
    bwd_any   = '0;
    for (int j = 0; j < MAX_POSITIONS; j++) begin
      if (below[j]) bwd_below = CNT_W'(j);
      if (free[j])  bwd_any   = CNT_W'(j);
    end
  end

  // Outcome of the request.
  always_comb begin
    new_valid = cur_valid_q;
    new_pos   = cur_pos_q;
    new_ok    = 1'b1;
    do_load   = 1'b0;
    if (!in_range_q) begin
      new_valid = 1'b0;
      new_ok    = 1'b0;
    end else begin
      unique case (req_q)
        REQ_GET: ;
        REQ_SET: begin
          if ((CNT_W'(pos_q) < npos) && !(|(mask_q & p_onehot))) begin
            new_valid = 1'b1;
            new_pos   = PW'(pos_q);
            do_load   = fire;
          end else begin
            new_ok = 1'b0;
          end
        end
        REQ_NEXT: begin
          if (|free) begin
            new_valid = 1'b1;
            new_pos   = PW'((|above) ? fwd_above : fwd_any);
            do_load   = fire;
          end
        end
        REQ_PREV: begin
          if (|free) begin
            new_valid = 1'b1;
            new_pos   = PW'((|below) ? bwd_below : bwd_any);
            do_load   = fire;
          end
        end
        REQ_DISABLE: begin
          new_valid = 1'b0;
          do_load   = fire;
        end
        default: new_ok = 1'b0;
      endcase
    end
  end

  assign new_pos_wide = 32'(new_pos);

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_pos <= new_valid ? new_pos_wide[RES_W-1:0] : RES_DISABLED;
      out_ok  <= new_ok;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_pos};
  assign m_axis_tuser  = out_ok;

  // A busy request whose result register is free finishes and clears busy.
  `ASSERT_CLK(a_done, clk, rst, (busy && (!out_valid || m_axis_tready)) |=> !busy)
  // An out-of-range slot answers -1 and not ok.
  `ASSERT_CLK(a_range, clk, rst, (fire && !in_range_q) |=> (out_valid && out_pos == RES_DISABLED && !out_ok))
  // No other slot holds the position of an enabled requesting slot.
  `ASSERT_NEVER(a_unique, clk, rst, busy && cur_valid_q && (|(mask_q & cur_onehot)))

endmodule

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for unique_position_allocator: random and directed
// requests are checked against a behavioral model of the slot table.
// Depends on upa_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb_top;
  import upa_pkg::*;

  localparam int NUM_SLOTS   = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 10;

  // Request kinds outside the defined set.
  localparam logic [REQ_W-1:0] REQ_BAD_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_BAD_LAST  = 3'd7;

  typedef struct {
    logic [REQ_W-1:0]  kind;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos;
    bit                drain;  // hold off until all results are back
  } request_t;

  typedef struct {
    logic [RES_W-1:0] pos;
    logic             ok;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;  // [3:0] slot, [7:4] position
  logic [2:0] s_axis_tuser  = '0;  // [2:0] req_type
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // [4:0] result_position, [7:5] zero
  logic [0:0] m_axis_tuser;        // [0] ok

  unique_position_allocator u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  request_t      pend_q[$];
  alloc_result_t want_q[$];
  int            err_count  = 0;
  int            cfg_writes = 0;
  int            cycles     = 0;

  // Mirror of the configuration and of the slot table.
  int unsigned      slot_cnt = 0;
  int unsigned      pos_cnt  = 16;
  bit               held[NUM_SLOTS];
  logic [POS_W-1:0] held_at[NUM_SLOTS];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at cycle %0d, %s: got %0d, expected %0d", cycles, what, got, want);
    err_count++;
  endtask

  function automatic int unsigned num_positions();
    return (pos_cnt > 16) ? 16 : pos_cnt;
  endfunction

  function automatic int unsigned active_slots();
    int unsigned a;
    a = slot_cnt;
    if (a > num_positions()) a = num_positions();
    if (a > NUM_SLOTS) a = NUM_SLOTS;
    return a;
  endfunction

  function automatic void release_from(input int unsigned first);
    for (int i = first; i < NUM_SLOTS; i++) begin
      held[i]    = 1'b0;
      held_at[i] = '0;
    end
  endfunction

  function automatic bit held_elsewhere(input int unsigned p, input int unsigned self);
    int unsigned a;
    a = active_slots();
    for (int unsigned i = 0; i < a; i++)
      if (i != self && held[i] && 32'(held_at[i]) == p) return 1'b1;
    return 1'b0;
  endfunction

  // Cyclic search for the first position no other slot holds.
  function automatic void seek_free(input int unsigned s, input bit fwd);
    int unsigned n, base, cand;
    n = num_positions();
    base = held[s] ? 32'(held_at[s]) : n - 1;
    for (int unsigned k = 0; k < n; k++) begin
      cand = fwd ? (base + 1 + k) % n : (base + 2 * n - 1 - k) % n;
      if (!held_elsewhere(cand, s)) begin
        held[s]    = 1'b1;
        held_at[s] = cand[POS_W-1:0];
        return;
      end
    end
  endfunction

  function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] val);
    if (idx == CFG_SLOT_COUNT) begin
      slot_cnt = 32'(val);
      release_from(active_slots());
    end else begin
      pos_cnt = 32'(val);
      release_from(0);
    end
  endfunction

  function automatic alloc_result_t allocate(input logic [REQ_W-1:0] kind,
                                             input logic [SLOT_W-1:0] slot,
                                             input logic [POS_W-1:0] p);
    alloc_result_t r;
    int unsigned   s;
    logic          ok;
    s  = 32'(slot);
    ok = 1'b1;
    if (s >= active_slots()) begin
      r.pos = RES_DISABLED;
      r.ok  = 1'b0;
      return r;
    end
    case (req_t'(kind))
      REQ_GET: ;
      REQ_SET: begin
        if (32'(p) >= num_positions() || held_elsewhere(32'(p), s)) begin
          ok = 1'b0;
        end else begin
          held[s]    = 1'b1;
          held_at[s] = p;
        end
      end
      REQ_NEXT: seek_free(s, 1'b1);
      REQ_PREV: seek_free(s, 1'b0);
      REQ_DISABLE: begin
        held[s]    = 1'b0;
        held_at[s] = '0;
      end
      default: ok = 1'b0;
    endcase
    r.pos = held[s] ? {1'b0, held_at[s]} : RES_DISABLED;
    r.ok  = ok;
    return r;
  endfunction

  // Idle gap for one item; zero during calm stretches.
  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // Request driver: presents queued items and predicts each accepted one.
  int send_wait = 0;
  bit send_calm = 1'b0;
  always @(posedge clk) begin
    logic     nv;
    request_t req;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      nv = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        want_q.push_back(allocate(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[7:4]));
        nv = 1'b0;
        if ($urandom_range(0, 99) < 2) send_calm = !send_calm;
        send_wait = draw_gap(send_calm);
      end
      if (!nv) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pend_q.size() > 0 && !(pend_q[0].drain && want_q.size() > 0)) begin
          req = pend_q.pop_front();
          s_axis_tuser <= req.kind;
          s_axis_tdata <= {req.pos, req.slot};
          nv = 1'b1;
        end
      end
      s_axis_tvalid <= nv;
    end
  end

  // Result monitor with random back-pressure.
  int recv_wait = 0;
  bit recv_calm = 1'b0;
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b1;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (want_q.size() == 0) begin
          report_mismatch("result transaction with none pending",
                          $signed(m_axis_tdata[4:0]), 0);
        end else begin
          want = want_q.pop_front();
          if (m_axis_tdata[4:0] !== want.pos)
            report_mismatch("result_position", $signed(m_axis_tdata[4:0]), $signed(want.pos));
          if (m_axis_tuser[0] !== want.ok)
            report_mismatch("ok", m_axis_tuser[0], want.ok);
        end
        if ($urandom_range(0, 99) < 2) recv_calm = !recv_calm;
        recv_wait = draw_gap(recv_calm);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      m_axis_tready <= (recv_wait == 0);
    end
  end

  // Configuration writes: mirror the register and close the transaction.
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      apply_config(cfg_index, cfg_data);
      cfg_valid <= 1'b0;
      cfg_writes++;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    int target;
    target = cfg_writes + 1;
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    while (cfg_writes < target) @(posedge clk);
  endtask

  // Sampled at the falling edge, after every update of the rising edge.
  task automatic wait_idle();
    while (pend_q.size() > 0 || s_axis_tvalid || want_q.size() > 0) @(negedge clk);
  endtask

  task automatic push_req(input logic [REQ_W-1:0] kind, input int slot, input int p);
    request_t r;
    r.kind  = kind;
    r.slot  = slot[SLOT_W-1:0];
    r.pos   = p[POS_W-1:0];
    r.drain = 1'b0;
    pend_q.push_back(r);
  endtask

  // Pick a register value, favoring the extremes and reaching past them.
  function automatic logic [CFG_W-1:0] pick_slot_count();
    case ($urandom_range(0, 9))
      0:       return 5'd0;
      1, 2:    return 5'd16;
      3:       return 5'd1;
      4:       return CFG_W'($urandom_range(17, 31));
      default: return CFG_W'($urandom_range(0, 16));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_pos_count();
    case ($urandom_range(0, 11))
      0:       return 5'd0;
      1:       return 5'd1;
      2, 3:    return 5'd16;
      4:       return CFG_W'($urandom_range(17, 31));
      5, 6:    return CFG_W'($urandom_range(2, 4));
      default: return CFG_W'($urandom_range(1, 16));
    endcase
  endfunction

  // Stimulus sequencing.
  initial begin
    request_t r;
    int       n_items, drain_at;
    int unsigned act, np;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset values: no active slots, every request is out of range.
    push_req(REQ_GET, 0, 0);
    push_req(REQ_NEXT, 15, 15);
    wait_idle();

    // Full table of sixteen slots over sixteen positions.
    write_reg(CFG_POS_COUNT, 5'd16);
    write_reg(CFG_SLOT_COUNT, 5'd16);
    push_req(REQ_GET, 0, 0);
    push_req(REQ_NEXT, 0, 0);
    push_req(REQ_PREV, 1, 0);
    push_req(REQ_SET, 2, 0);
    push_req(REQ_SET, 2, 15);
    push_req(REQ_NEXT, 1, 0);
    push_req(REQ_PREV, 0, 0);
    push_req(REQ_NEXT, 15, 0);
    push_req(REQ_DISABLE, 0, 0);
    push_req(REQ_GET, 0, 0);
    push_req(REQ_BAD_FIRST, 1, 0);
    push_req(REQ_BAD_LAST, 15, 15);
    wait_idle();

    // Two slots over two positions: searches that find nothing free.
    write_reg(CFG_POS_COUNT, 5'd2);
    write_reg(CFG_SLOT_COUNT, 5'd3);
    push_req(REQ_NEXT, 0, 0);
    push_req(REQ_NEXT, 1, 0);
    push_req(REQ_NEXT, 0, 0);
    push_req(REQ_PREV, 1, 0);
    push_req(REQ_SET, 0, 1);
    push_req(REQ_SET, 1, 3);
    push_req(REQ_GET, 2, 0);
    wait_idle();

    // Shrinking the slot count keeps the lower slots.
    write_reg(CFG_SLOT_COUNT, 5'd1);
    push_req(REQ_GET, 0, 0);
    push_req(REQ_GET, 1, 0);
    wait_idle();

    // Random phases, each under its own settings.
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 3))
        0: write_reg(CFG_SLOT_COUNT, pick_slot_count());
        1: write_reg(CFG_POS_COUNT, pick_pos_count());
        default: begin
          write_reg(CFG_POS_COUNT, pick_pos_count());
          write_reg(CFG_SLOT_COUNT, pick_slot_count());
        end
      endcase
      // Keep most phases useful: rescue a setting with no active slots.
      if (active_slots() == 0 && $urandom_range(0, 3) != 0) begin
        if (num_positions() == 0) write_reg(CFG_POS_COUNT, CFG_W'($urandom_range(1, 16)));
        write_reg(CFG_SLOT_COUNT, CFG_W'($urandom_range(1, 16)));
      end
      act = active_slots();
      np  = num_positions();
      n_items  = $urandom_range(80, 100);
      drain_at = $urandom_range(10, n_items - 10);
      for (int i = 0; i < n_items; i++) begin
        case ($urandom_range(0, 19))
          0:       r.kind = REQ_W'($urandom_range(REQ_BAD_FIRST, REQ_BAD_LAST));
          1, 2:    r.kind = REQ_DISABLE;
          3, 4, 5: r.kind = REQ_GET;
          6, 7, 8, 9: r.kind = REQ_SET;
          10, 11, 12, 13, 14: r.kind = REQ_NEXT;
          default: r.kind = REQ_PREV;
        endcase
        if (act > 0 && $urandom_range(0, 9) != 0) r.slot = SLOT_W'($urandom_range(0, act - 1));
        else r.slot = SLOT_W'($urandom_range(0, 15));
        if (np > 0 && $urandom_range(0, 7) != 0) r.pos = POS_W'($urandom_range(0, np - 1));
        else r.pos = POS_W'($urandom_range(0, 15));
        r.drain = (i == drain_at);
        pend_q.push_back(r);
      end
      wait_idle();
    end

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (want_q.size() != 0) report_mismatch("results never delivered", 0, want_q.size());
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/upa_pkg.sv
hw/rtl/upa_cell.sv
hw/rtl/unique_position_allocator.sv
test/tb_top.sv
